>>> rtl/core/assert_macros.svh
// Assertion helpers for the checker file lits_checker.sv.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LITS_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("concurrent assertion failed");

// Next-cycle implication.
`define LITS_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("concurrent assertion failed");

`endif

>>> rtl/core/lits_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lits_pkg
// Shared command codes, item kinds and the front-to-back control struct.
// ----------------------------------------------------------------------------
package lits_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_PUSH_IMU   = 2'd0;
    localparam op_t OP_PUSH_LIDAR = 2'd1;
    localparam op_t OP_POLL       = 2'd2;
    localparam op_t OP_NONE       = 2'd3;

    localparam logic KIND_LIDAR = 1'b0;
    localparam logic KIND_IMU   = 1'b1;

    // Depth of the command queue between the front and back parts.
    localparam int CMD_DEPTH = 2;

    typedef struct packed {
        logic valid;
        op_t  op;
    } cmd_ctl_t;

endpackage

>>> rtl/core/lits_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lits_front
// Accepts requests, drops unused codes and queues the rest for the back part.
// ----------------------------------------------------------------------------
module lits_front #(
    parameter int TIME_BITS = 48,
    parameter int TAG_BITS  = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  lits_pkg::op_t               mode,
    input  logic signed [TIME_BITS-1:0] stamp,
    input  logic signed [TIME_BITS-1:0] frame_end,
    input  logic [TAG_BITS-1:0]         tag,
    output lits_pkg::cmd_ctl_t          cmd,
    input  logic                        cmd_ready,
    output logic signed [TIME_BITS-1:0] cmd_stamp,
    output logic signed [TIME_BITS-1:0] cmd_end,
    output logic [TAG_BITS-1:0]         cmd_tag
);
    import lits_pkg::*;

    localparam int QW = $clog2(CMD_DEPTH);
    localparam int QCW = $clog2(CMD_DEPTH + 1);

    logic [QCW-1:0]              q_count_reg, q_count_next;
    logic [QW-1:0]               q_head_reg, q_head_next;
    logic [QW-1:0]               q_tail;
    op_t                         q_op_reg    [CMD_DEPTH];
    logic signed [TIME_BITS-1:0] q_stamp_reg [CMD_DEPTH];
    logic signed [TIME_BITS-1:0] q_end_reg   [CMD_DEPTH];
    logic [TAG_BITS-1:0]         q_tag_reg   [CMD_DEPTH];
    logic                        keep;
    logic                        enq;
    logic                        deq;

    always_comb
    begin
        unique case (mode) inside
            OP_PUSH_IMU, OP_PUSH_LIDAR, OP_POLL: keep = 1'b1;
            default:                             keep = 1'b0;
        endcase
    end

    assign in_ready = (q_count_reg != QCW'(CMD_DEPTH));
    assign enq      = in_valid && in_ready && keep;
    assign deq      = cmd.valid && cmd_ready;
    assign q_tail   = QW'((QCW'(q_head_reg) + q_count_reg) % QCW'(CMD_DEPTH));

    assign cmd.valid = (q_count_reg != '0);
    assign cmd.op    = q_op_reg[q_head_reg];
    assign cmd_stamp = q_stamp_reg[q_head_reg];
    assign cmd_end   = q_end_reg[q_head_reg];
    assign cmd_tag   = q_tag_reg[q_head_reg];

    always_comb
    begin
        q_count_next = q_count_reg + QCW'(enq) - QCW'(deq);
        q_head_next  = q_head_reg;
        if (deq)
        begin
            q_head_next = (q_head_reg == QW'(CMD_DEPTH - 1)) ? '0 : q_head_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_count_reg <= '0;
            q_head_reg  <= '0;
        end
        else
        begin
            q_count_reg <= q_count_next;
            q_head_reg  <= q_head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_op_reg[q_tail]    <= mode;
            q_stamp_reg[q_tail] <= stamp;
            q_end_reg[q_tail]   <= frame_end;
            q_tag_reg[q_tail]   <= tag;
        end
    end

endmodule

>>> rtl/core/lits_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lits_back
// Holds the IMU and lidar queues, executes pushes and polls, and streams
// each synced package through a registered output stage.
// ----------------------------------------------------------------------------
module lits_back #(
    parameter int IMU_DEPTH   = 32,
    parameter int LIDAR_DEPTH = 4,
    parameter int TIME_BITS   = 48,
    parameter int TAG_BITS    = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lits_pkg::cmd_ctl_t          cmd,
    output logic                        cmd_ready,
    input  logic signed [TIME_BITS-1:0] cmd_stamp,
    input  logic signed [TIME_BITS-1:0] cmd_end,
    input  logic [TAG_BITS-1:0]         cmd_tag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        kind,
    output logic signed [TIME_BITS-1:0] out_stamp,
    output logic signed [TIME_BITS-1:0] out_end,
    output logic [TAG_BITS-1:0]         out_tag,
    output logic                        last
);
    import lits_pkg::*;

    localparam int IW  = $clog2(IMU_DEPTH);
    localparam int ICW = $clog2(IMU_DEPTH + 1);
    localparam int LW  = $clog2(LIDAR_DEPTH);
    localparam int LCW = $clog2(LIDAR_DEPTH + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    function automatic logic time_lt(input logic signed [TIME_BITS-1:0] a,
                                     input logic signed [TIME_BITS-1:0] b);
        return a < b;
    endfunction

    function automatic logic [IW-1:0] imu_inc(input logic [IW-1:0] h);
        return (h == IW'(IMU_DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

    function automatic logic [LW-1:0] lidar_inc(input logic [LW-1:0] h);
        return (h == LW'(LIDAR_DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

    // Control state
    logic           state_reg, state_next;
    logic [IW-1:0]  imu_head_reg, imu_head_next;
    logic [ICW-1:0] imu_count_reg, imu_count_next;
    logic [LW-1:0]  lidar_head_reg, lidar_head_next;
    logic [LCW-1:0] lidar_count_reg, lidar_count_next;
    logic           pending_valid_reg, pending_valid_next;
    logic           out_valid_reg, out_valid_next;

    // Stores and payload registers
    logic signed [TIME_BITS-1:0] imu_time_mem   [IMU_DEPTH];
    logic [TAG_BITS-1:0]         imu_tag_mem    [IMU_DEPTH];
    logic signed [TIME_BITS-1:0] lidar_start_reg [LIDAR_DEPTH];
    logic signed [TIME_BITS-1:0] lidar_end_reg   [LIDAR_DEPTH];
    logic [TAG_BITS-1:0]         lidar_tag_reg   [LIDAR_DEPTH];
    logic signed [TIME_BITS-1:0] rd_time_reg;
    logic [TAG_BITS-1:0]         rd_tag_reg;
    logic signed [TIME_BITS-1:0] imu_newest_reg;
    logic signed [TIME_BITS-1:0] lidar_newest_reg;
    logic signed [TIME_BITS-1:0] pending_start_reg;
    logic signed [TIME_BITS-1:0] pending_end_reg;
    logic [TAG_BITS-1:0]         pending_tag_reg;
    logic                        held_kind_reg;
    logic signed [TIME_BITS-1:0] held_stamp_reg;
    logic signed [TIME_BITS-1:0] held_end_reg;
    logic [TAG_BITS-1:0]         held_tag_reg;
    logic                        out_kind_reg;
    logic signed [TIME_BITS-1:0] out_stamp_reg;
    logic signed [TIME_BITS-1:0] out_end_reg;
    logic [TAG_BITS-1:0]         out_tag_reg;
    logic                        out_last_reg;

    // IMU push datapath
    logic           imu_clear;
    logic [IW-1:0]  imu_push_head;
    logic [ICW-1:0] imu_push_count;
    logic [ICW:0]   imu_sum;
    logic [IW-1:0]  imu_slot;

    // Lidar push datapath
    logic           lidar_clear;
    logic [LW-1:0]  lidar_push_head;
    logic [LCW-1:0] lidar_push_count;
    logic [LCW:0]   lidar_sum;
    logic [LW-1:0]  lidar_slot;

    // Poll datapath
    logic signed [TIME_BITS-1:0] frame_start;
    logic signed [TIME_BITS-1:0] frame_stop;
    logic [TAG_BITS-1:0]         frame_tag;
    logic                        imu_hit;

    // Enables
    logic cmd_go;
    logic load_ok;
    logic imu_we;
    logic lidar_we;
    logic pend_latch;
    logic held_load_frame;
    logic held_load_imu;
    logic out_load;
    logic out_last_next;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_go    = cmd.valid && cmd_ready;
    assign load_ok   = !out_valid_reg || out_ready;

    // A non-negative IMU time older than the newest sample restarts the queue.
    always_comb
    begin
        imu_clear = !cmd_stamp[TIME_BITS-1] && (imu_count_reg != '0)
                    && time_lt(cmd_stamp, imu_newest_reg);
        imu_push_head  = imu_clear ? '0 : imu_head_reg;
        imu_push_count = imu_clear ? '0 : imu_count_reg;
        if (imu_push_count == ICW'(IMU_DEPTH))
        begin
            imu_push_head  = imu_inc(imu_push_head);
            imu_push_count = ICW'(IMU_DEPTH - 1);
        end
        imu_sum  = (ICW+1)'(imu_push_head) + (ICW+1)'(imu_push_count);
        imu_slot = (imu_sum >= (ICW+1)'(IMU_DEPTH)) ? IW'(imu_sum - (ICW+1)'(IMU_DEPTH))
                                                    : IW'(imu_sum);
    end

    always_comb
    begin
        lidar_clear = (lidar_count_reg != '0) && time_lt(cmd_stamp, lidar_newest_reg);
        lidar_push_head  = lidar_clear ? '0 : lidar_head_reg;
        lidar_push_count = lidar_clear ? '0 : lidar_count_reg;
        if (lidar_push_count == LCW'(LIDAR_DEPTH))
        begin
            lidar_push_head  = lidar_inc(lidar_push_head);
            lidar_push_count = LCW'(LIDAR_DEPTH - 1);
        end
        lidar_sum  = (LCW+1)'(lidar_push_head) + (LCW+1)'(lidar_push_count);
        lidar_slot = (lidar_sum >= (LCW+1)'(LIDAR_DEPTH))
                     ? LW'(lidar_sum - (LCW+1)'(LIDAR_DEPTH)) : LW'(lidar_sum);
    end

    // The frame a poll works on: the pending copy, or the lidar front when none is held.
    assign frame_start = pending_valid_reg ? pending_start_reg : lidar_start_reg[lidar_head_reg];
    assign frame_stop  = pending_valid_reg ? pending_end_reg   : lidar_end_reg[lidar_head_reg];
    assign frame_tag   = pending_valid_reg ? pending_tag_reg   : lidar_tag_reg[lidar_head_reg];

    assign imu_hit = (imu_count_reg != '0) && time_lt(rd_time_reg, pending_end_reg);

    always_comb
    begin
        state_next         = state_reg;
        imu_head_next      = imu_head_reg;
        imu_count_next     = imu_count_reg;
        lidar_head_next    = lidar_head_reg;
        lidar_count_next   = lidar_count_reg;
        pending_valid_next = pending_valid_reg;
        imu_we             = 1'b0;
        lidar_we           = 1'b0;
        pend_latch         = 1'b0;
        held_load_frame    = 1'b0;
        held_load_imu      = 1'b0;
        out_load           = 1'b0;
        out_last_next      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_go)
                begin
                    case (cmd.op)
                        OP_PUSH_IMU:
                        begin
                            imu_we         = 1'b1;
                            imu_head_next  = imu_push_head;
                            imu_count_next = imu_push_count + 1'b1;
                        end
                        OP_PUSH_LIDAR:
                        begin
                            lidar_we         = 1'b1;
                            lidar_head_next  = lidar_push_head;
                            lidar_count_next = lidar_push_count + 1'b1;
                        end
                        OP_POLL:
                        begin
                            if (imu_count_reg != '0 && lidar_count_reg != '0)
                            begin
                                pend_latch         = !pending_valid_reg;
                                pending_valid_next = 1'b1;
                                if (!time_lt(imu_newest_reg, frame_stop))
                                begin
                                    held_load_frame = 1'b1;
                                    state_next      = ST_DRAIN;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                // The held item goes out once we know whether another follows it.
                if (load_ok)
                begin
                    out_load      = 1'b1;
                    out_last_next = !imu_hit;
                    if (imu_hit)
                    begin
                        held_load_imu  = 1'b1;
                        imu_head_next  = imu_inc(imu_head_reg);
                        imu_count_next = imu_count_reg - 1'b1;
                    end
                    else
                    begin
                        lidar_head_next    = lidar_inc(lidar_head_reg);
                        lidar_count_next   = lidar_count_reg - 1'b1;
                        pending_valid_next = 1'b0;
                        state_next         = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            imu_head_reg      <= '0;
            imu_count_reg     <= '0;
            lidar_head_reg    <= '0;
            lidar_count_reg   <= '0;
            pending_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            imu_head_reg      <= imu_head_next;
            imu_count_reg     <= imu_count_next;
            lidar_head_reg    <= lidar_head_next;
            lidar_count_reg   <= lidar_count_next;
            pending_valid_reg <= pending_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // IMU store: one write port, one registered read port that follows the head.
    always_ff @(posedge clk)
    begin
        if (imu_we)
        begin
            imu_time_mem[imu_slot] <= cmd_stamp;
            imu_tag_mem[imu_slot]  <= cmd_tag;
        end
        rd_time_reg <= imu_time_mem[imu_head_next];
        rd_tag_reg  <= imu_tag_mem[imu_head_next];
    end

    always_ff @(posedge clk)
    begin
        if (imu_we)
        begin
            imu_newest_reg <= cmd_stamp;
        end
        if (lidar_we)
        begin
            lidar_start_reg[lidar_slot] <= cmd_stamp;
            lidar_end_reg[lidar_slot]   <= cmd_end;
            lidar_tag_reg[lidar_slot]   <= cmd_tag;
            lidar_newest_reg            <= cmd_stamp;
        end
        if (pend_latch)
        begin
            pending_start_reg <= lidar_start_reg[lidar_head_reg];
            pending_end_reg   <= lidar_end_reg[lidar_head_reg];
            pending_tag_reg   <= lidar_tag_reg[lidar_head_reg];
        end
        if (held_load_frame)
        begin
            held_kind_reg  <= KIND_LIDAR;
            held_stamp_reg <= frame_start;
            held_end_reg   <= frame_stop;
            held_tag_reg   <= frame_tag;
        end
        else if (held_load_imu)
        begin
            held_kind_reg  <= KIND_IMU;
            held_stamp_reg <= rd_time_reg;
            held_end_reg   <= '0;
            held_tag_reg   <= rd_tag_reg;
        end
        if (out_load)
        begin
            out_kind_reg  <= held_kind_reg;
            out_stamp_reg <= held_stamp_reg;
            out_end_reg   <= held_end_reg;
            out_tag_reg   <= held_tag_reg;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign out_stamp = out_stamp_reg;
    assign out_end   = out_end_reg;
    assign out_tag   = out_tag_reg;
    assign last      = out_last_reg;

endmodule

>>> rtl/core/lidar_imu_timestamp_sync_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_imu_timestamp_sync_top
// Pairs queued lidar frames with the IMU samples that precede their end time.
// ----------------------------------------------------------------------------
// Requests enter a two-entry command queue and are executed one at a time by
// the back part. A poll first decides whether a package is ready; if so, it
// streams the frame and each IMU sample before the frame end at one item per
// cycle while the output is not stalled, limited by the single registered read
// port of the IMU store. Requests keep queueing in front while a package
// drains, until the command queue fills.
module lidar_imu_timestamp_sync_top #(
    parameter int IMU_DEPTH   = 32,
    parameter int LIDAR_DEPTH = 4,
    parameter int TIME_BITS   = 48,
    parameter int TAG_BITS    = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  lits_pkg::op_t               mode,
    input  logic signed [TIME_BITS-1:0] stamp,
    input  logic signed [TIME_BITS-1:0] frame_end,
    input  logic [TAG_BITS-1:0]         tag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        kind,
    output logic signed [TIME_BITS-1:0] out_stamp,
    output logic signed [TIME_BITS-1:0] out_end,
    output logic [TAG_BITS-1:0]         out_tag,
    output logic                        last
);
    import lits_pkg::*;

    cmd_ctl_t                    cmd;
    logic                        cmd_ready;
    logic signed [TIME_BITS-1:0] cmd_stamp;
    logic signed [TIME_BITS-1:0] cmd_end;
    logic [TAG_BITS-1:0]         cmd_tag;

    lits_front #(
        .TIME_BITS (TIME_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .stamp     (stamp),
        .frame_end (frame_end),
        .tag       (tag),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .cmd_stamp (cmd_stamp),
        .cmd_end   (cmd_end),
        .cmd_tag   (cmd_tag)
    );

    lits_back #(
        .IMU_DEPTH   (IMU_DEPTH),
        .LIDAR_DEPTH (LIDAR_DEPTH),
        .TIME_BITS   (TIME_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .cmd_stamp (cmd_stamp),
        .cmd_end   (cmd_end),
        .cmd_tag   (cmd_tag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .out_stamp (out_stamp),
        .out_end   (out_end),
        .out_tag   (out_tag),
        .last      (last)
    );

endmodule

>>> rtl/core/lits_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lits_checker
// Port-level checks on the result stream of the synchronizer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lits_checker #(
    parameter int TIME_BITS = 48,
    parameter int TAG_BITS  = 32
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        kind,
    input logic signed [TIME_BITS-1:0] out_stamp,
    input logic signed [TIME_BITS-1:0] out_end,
    input logic [TAG_BITS-1:0]         out_tag,
    input logic                        last
);
    import lits_pkg::*;

    logic [2*TIME_BITS+TAG_BITS+1:0] out_fields;

    assign out_fields = {kind, out_stamp, out_end, out_tag, last};

    `LITS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `LITS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_fields))
    `LITS_ASSERT_NOW(a_imu_no_end, out_valid && kind == KIND_IMU, out_end == '0)
    // Within a package the next item is always valid in the cycle after the previous one left.
    `LITS_ASSERT_NEXT(a_pkg_streams, out_valid && out_ready && !last, out_valid)

endmodule

bind lidar_imu_timestamp_sync_top lits_checker #(
    .TIME_BITS (TIME_BITS),
    .TAG_BITS  (TAG_BITS)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_stamp (out_stamp),
    .out_end   (out_end),
    .out_tag   (out_tag),
    .last      (last)
);

>>> tb/sync_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_tb_pkg
// Scoreboard for the lidar/IMU synchronizer: tracks both sensor queues and
// the pending frame, and predicts the package items that each poll releases.
// ----------------------------------------------------------------------------
package sync_tb_pkg;

    import lits_pkg::*;

    localparam int IMU_SLOTS   = 32;
    localparam int FRAME_SLOTS = 4;

    typedef logic signed [47:0] usec_t;
    typedef logic [31:0]        handle_t;

    typedef struct packed {
        logic    kind;
        usec_t   stamp;
        usec_t   stop;
        handle_t tag;
        logic    last;
    } sync_item_t;

    class sync_scoreboard;
        usec_t      imu_time [IMU_SLOTS];
        handle_t    imu_tag [IMU_SLOTS];
        int         imu_head;
        int         imu_count;
        usec_t      frame_start [FRAME_SLOTS];
        usec_t      frame_stop [FRAME_SLOTS];
        handle_t    frame_tag [FRAME_SLOTS];
        int         frame_head;
        int         frame_count;
        bit         held;
        usec_t      held_start;
        usec_t      held_stop;
        handle_t    held_tag;
        sync_item_t due_items[$];
        int         mismatches;

        function new();
            imu_head    = 0;
            imu_count   = 0;
            frame_head  = 0;
            frame_count = 0;
            held        = 1'b0;
            held_start  = '0;
            held_stop   = '0;
            held_tag    = '0;
            mismatches  = 0;
        endfunction

        function int waiting();
            return due_items.size();
        endfunction

        function void push_imu(usec_t t, handle_t tg);
            int slot;
            // Only a non-negative sample that goes back in time restarts the queue.
            if (!t[47] && imu_count > 0) begin
                if (t < imu_time[(imu_head + imu_count - 1) % IMU_SLOTS]) begin
                    imu_count = 0;
                    imu_head  = 0;
                end
            end
            if (imu_count >= IMU_SLOTS) begin
                imu_head  = (imu_head + 1) % IMU_SLOTS;
                imu_count = IMU_SLOTS - 1;
            end
            slot           = (imu_head + imu_count) % IMU_SLOTS;
            imu_time[slot] = t;
            imu_tag[slot]  = tg;
            imu_count++;
        endfunction

        function void push_frame(usec_t s, usec_t e, handle_t tg);
            int slot;
            if (frame_count > 0) begin
                if (s < frame_start[(frame_head + frame_count - 1) % FRAME_SLOTS]) begin
                    frame_count = 0;
                    frame_head  = 0;
                end
            end
            if (frame_count >= FRAME_SLOTS) begin
                frame_head  = (frame_head + 1) % FRAME_SLOTS;
                frame_count = FRAME_SLOTS - 1;
            end
            slot              = (frame_head + frame_count) % FRAME_SLOTS;
            frame_start[slot] = s;
            frame_stop[slot]  = e;
            frame_tag[slot]   = tg;
            frame_count++;
        endfunction

        function void poll_sensors();
            sync_item_t bundle[$];
            sync_item_t item;
            if (imu_count == 0 || frame_count == 0)
                return;
            if (!held) begin
                held       = 1'b1;
                held_start = frame_start[frame_head];
                held_stop  = frame_stop[frame_head];
                held_tag   = frame_tag[frame_head];
            end
            if (imu_time[(imu_head + imu_count - 1) % IMU_SLOTS] < held_stop)
                return;
            item = '{kind: KIND_LIDAR, stamp: held_start, stop: held_stop,
                     tag: held_tag, last: 1'b0};
            bundle.insert(bundle.size(), item);
            while (imu_count > 0 && imu_time[imu_head] < held_stop) begin
                item = '{kind: KIND_IMU, stamp: imu_time[imu_head], stop: '0,
                         tag: imu_tag[imu_head], last: 1'b0};
                bundle.insert(bundle.size(), item);
                imu_head = (imu_head + 1) % IMU_SLOTS;
                imu_count--;
            end
            bundle[bundle.size() - 1].last = 1'b1;
            foreach (bundle[i])
                due_items.insert(due_items.size(), bundle[i]);
            // The front frame is popped even if it is not the held copy.
            frame_head = (frame_head + 1) % FRAME_SLOTS;
            frame_count--;
            held = 1'b0;
        endfunction

        function void note_request(op_t op, usec_t st, usec_t fe, handle_t tg);
            case (op)
                OP_PUSH_IMU:   push_imu(st, tg);
                OP_PUSH_LIDAR: push_frame(st, fe, tg);
                OP_POLL:       poll_sensors();
                default:       ;
            endcase
        endfunction

        function void check_item(sync_item_t got);
            sync_item_t want;
            if (due_items.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind=%0d stamp=%0d end=%0d tag=%h last=%0d",
                             got.kind, got.stamp, got.stop, got.tag, got.last);
                return;
            end
            want = due_items[0];
            due_items.delete(0);
            if (got.kind !== want.kind || got.stamp !== want.stamp ||
                got.stop !== want.stop || got.tag !== want.tag || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: exp kind=%0d stamp=%0d end=%0d tag=%h last=%0d",
                             want.kind, want.stamp, want.stop, want.tag, want.last);
                    $display("                 got kind=%0d stamp=%0d end=%0d tag=%h last=%0d",
                             got.kind, got.stamp, got.stop, got.tag, got.last);
                end
            end
        endfunction
    endclass

endpackage

>>> tb/tb_lidar_imu_timestamp_sync_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_imu_timestamp_sync_top
// Drives IMU pushes, lidar pushes and polls into the synchronizer and checks
// every package item against a scoreboard that tracks both sensor queues.
// A directed opener covers time extremes, reordering, the held frame and the
// unused mode; random sensor streams, queue floods and noise follow, with
// random gaps on both sides and long output stalls that back up the input.
// ----------------------------------------------------------------------------
module tb_lidar_imu_timestamp_sync_top;

    import lits_pkg::*;
    import sync_tb_pkg::*;

    localparam usec_t TIME_MIN     = {1'b1, 47'd0};
    localparam usec_t TIME_MAX     = {1'b0, {47{1'b1}}};
    localparam int    RANDOM_ITEMS = 190;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    op_t         mode;
    usec_t       stamp;
    usec_t       frame_end;
    handle_t     tag;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    usec_t       out_stamp;
    usec_t       out_end;
    handle_t     out_tag;
    logic        last;

    sync_scoreboard sb;
    int             requests_sent;
    int             hold_cycles;
    bit             tight_phase;
    usec_t          imu_clock;
    usec_t          frame_clock;

    lidar_imu_timestamp_sync_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .stamp     (stamp),
        .frame_end (frame_end),
        .tag       (tag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .out_stamp (out_stamp),
        .out_end   (out_end),
        .out_tag   (out_tag),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic usec_t random_usec();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[47:0];
    endfunction

    function automatic usec_t pick_base();
        case ($urandom_range(0, 3))
            0:       return usec_t'($urandom_range(0, 100000));
            1:       return TIME_MAX - usec_t'($urandom_range(500, 4000));
            2:       return TIME_MIN + usec_t'($urandom_range(0, 4000));
            default: return random_usec();
        endcase
    endfunction

    // Called right after a rising edge; returns on the edge that accepts the request.
    task automatic send_request(input op_t op, input usec_t st, input usec_t fe,
                                input handle_t tg);
        int gap;
        gap = tight_phase ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= op;
        stamp     <= st;
        frame_end <= fe;
        tag       <= tg;
        do
            @(negedge clk);
        while (!in_ready);
        sb.note_request(op, st, fe, tg);
        if (op != OP_NONE)
            requests_sent++;
        @(posedge clk);
    endtask

    // Ordered IMU and lidar traffic with polls mixed in, so packages form.
    task automatic run_sensor_stream(input int count);
        int    pick;
        usec_t dur;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                imu_clock = imu_clock + usec_t'($urandom_range(1, 40));
                send_request(OP_PUSH_IMU, imu_clock, random_usec(), $urandom);
            end
            else if (pick < 7)
            begin
                dur = usec_t'($urandom_range(20, 80));
                send_request(OP_PUSH_LIDAR, frame_clock, frame_clock + dur, $urandom);
                frame_clock = frame_clock + dur;
            end
            else
            begin
                send_request(OP_POLL, random_usec(), random_usec(), $urandom);
            end
        end
    endtask

    // One long frame with more samples than the IMU queue holds, then its package.
    task automatic run_imu_flood();
        if (imu_clock > frame_clock)
            frame_clock = imu_clock;
        else
            imu_clock = frame_clock;
        send_request(OP_PUSH_LIDAR, frame_clock, frame_clock + 2000, $urandom);
        repeat (34)
        begin
            imu_clock = imu_clock + usec_t'($urandom_range(1, 40));
            send_request(OP_PUSH_IMU, imu_clock, random_usec(), $urandom);
        end
        send_request(OP_POLL, random_usec(), random_usec(), $urandom);
        frame_clock = frame_clock + 2000;
        imu_clock   = frame_clock + usec_t'($urandom_range(0, 5));
        send_request(OP_PUSH_IMU, imu_clock, random_usec(), $urandom);
        repeat (2) send_request(OP_POLL, random_usec(), random_usec(), $urandom);
    endtask

    // More frames than the lidar queue holds, then enough polls to drain it.
    task automatic run_frame_flood();
        usec_t dur;
        repeat (6)
        begin
            dur = usec_t'($urandom_range(20, 80));
            send_request(OP_PUSH_LIDAR, frame_clock, frame_clock + dur, $urandom);
            frame_clock = frame_clock + dur;
        end
        imu_clock = frame_clock + usec_t'($urandom_range(1, 10));
        send_request(OP_PUSH_IMU, imu_clock, random_usec(), $urandom);
        repeat (6) send_request(OP_POLL, random_usec(), random_usec(), $urandom);
    endtask

    task automatic run_noise(input int count);
        repeat (count)
            send_request(op_t'($urandom_range(0, 3)), random_usec(), random_usec(), $urandom);
        imu_clock   = pick_base();
        frame_clock = imu_clock;
    endtask

    initial
    begin : output_side
        int         stall;
        sync_item_t got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = tight_phase ? 0 : $urandom_range(0, 10);
            if (hold_cycles > 0)
            begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(negedge clk);
            while (!out_valid && hold_cycles == 0);
            if (out_valid)
            begin
                got = '{kind: kind, stamp: out_stamp, stop: out_end, tag: out_tag, last: last};
                sb.check_item(got);
            end
            @(posedge clk);
        end
    end

    initial
    begin : input_side
        int random_start;
        sb            = new();
        requests_sent = 0;
        hold_cycles   = 0;
        tight_phase   = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = OP_NONE;
        stamp         = '0;
        frame_end     = '0;
        tag           = '0;
        out_ready     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Polls with empty queues and the unused mode release nothing.
        send_request(OP_POLL, TIME_MAX, TIME_MIN, 32'hFFFF_FFFF);
        send_request(OP_NONE, TIME_MIN, TIME_MAX, 32'hFFFF_FFFF);
        send_request(OP_PUSH_IMU, TIME_MIN, TIME_MAX, 32'h0000_0000);
        send_request(OP_POLL, '0, '0, '0);
        send_request(OP_PUSH_LIDAR, TIME_MIN, TIME_MIN + 10, 32'hFFFF_FFFF);
        // Newest sample is still before the frame end: frame is held, nothing released.
        send_request(OP_POLL, '0, '0, '0);
        send_request(OP_PUSH_IMU, 100, '0, 32'h0000_0001);
        send_request(OP_POLL, '0, '0, '0);
        // A sample back in time clears the IMU queue; a negative one never does.
        send_request(OP_PUSH_IMU, 50, TIME_MIN, 32'h0000_0002);
        send_request(OP_PUSH_IMU, -5, TIME_MAX, 32'h0000_0003);
        send_request(OP_PUSH_LIDAR, 1000, 1000, 32'hA5A5_0001);
        send_request(OP_PUSH_LIDAR, 500, 600, 32'hA5A5_0002);
        send_request(OP_POLL, '0, '0, '0);
        // The held frame survives a cleared lidar queue; the package pops the new front.
        send_request(OP_PUSH_LIDAR, 400, 450, 32'hA5A5_0003);
        send_request(OP_PUSH_IMU, 700, '0, 32'h0000_0004);
        send_request(OP_POLL, '0, '0, '0);
        send_request(OP_PUSH_LIDAR, TIME_MAX, TIME_MAX, 32'h5A5A_0004);
        send_request(OP_PUSH_IMU, TIME_MAX, '0, 32'h0000_0005);
        send_request(OP_POLL, '0, '0, '0);
        // No sample lies before this end, so the frame alone forms the package.
        send_request(OP_PUSH_LIDAR, TIME_MAX, '0, 32'h5A5A_0005);
        send_request(OP_POLL, '0, '0, '0);
        send_request(OP_NONE, '0, '0, '0);

        random_start = requests_sent;
        imu_clock    = pick_base();
        frame_clock  = imu_clock;

        // The output stalls for a long stretch while requests keep coming.
        tight_phase = 1'b1;
        hold_cycles = 300;
        run_sensor_stream(30);

        while (requests_sent - random_start < RANDOM_ITEMS)
        begin
            tight_phase = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: run_sensor_stream($urandom_range(10, 24));
                6:                run_imu_flood();
                7:                run_frame_flood();
                8:                run_noise($urandom_range(4, 8));
                default:
                begin
                    hold_cycles = $urandom_range(50, 150);
                    run_sensor_stream(16);
                end
            endcase
        end
        tight_phase = 1'b0;
        in_valid <= 1'b0;

        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lits_pkg.sv
rtl/core/lits_front.sv
rtl/core/lits_back.sv
rtl/core/lidar_imu_timestamp_sync_top.sv
rtl/core/lits_checker.sv
tb/sync_tb_pkg.sv
tb/tb_lidar_imu_timestamp_sync_top.sv
